>>> hw/rtl/idql_pkg.sv
// shared types and codes for the indexed deque list engine
`default_nettype none

package idql_pkg;

    localparam int CAPACITY_DEF  = 64;
    localparam int ITEM_BITS_DEF = 32;

    localparam int MODE_W   = 4;
    localparam int POS_W    = 8;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int FIDX_W   = 6;
    localparam int LEN_W    = 7;
    localparam int GROUP_W  = 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND      = 4'd0,
        MODE_APPEND_HEAD = 4'd1,
        MODE_POP_TAIL    = 4'd2,
        MODE_POP_HEAD    = 4'd3,
        MODE_INSERT      = 4'd4,
        MODE_REMOVE      = 4'd5,
        MODE_FIND        = 4'd6,
        MODE_PEEK_HEAD   = 4'd7,
        MODE_PEEK_TAIL   = 4'd8,
        MODE_CLEAR       = 4'd9
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_REM  = 2'd2
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_SCAN = 2'd2,
        ST_DONE = 2'd3
    } fsm_t;

    // broadcast control seen by every cell
    typedef struct packed {
        cell_op_t op;
        logic     cmp_en;
        logic     rd_en;
    } cell_ctrl_t;

    // scan unit status back to the sequencer
    typedef struct packed {
        logic done;
        logic found;
    } scan_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/idql_cell.sv
// one storage cell of the list chain: shift, compare and read tap
`default_nettype none

module idql_cell #(
    parameter int CAPACITY  = idql_pkg::CAPACITY_DEF,
    parameter int ITEM_BITS = idql_pkg::ITEM_BITS_DEF,
    parameter int IDX       = 0
) (
    input  wire                                   clk,
    input  wire idql_pkg::cell_ctrl_t             ctrl,
    input  wire [$clog2(CAPACITY)-1:0]            at_idx,
    input  wire [$clog2(CAPACITY+1)-1:0]          count,
    input  wire [ITEM_BITS-1:0]                   item,
    input  wire [ITEM_BITS-1:0]                   left_data,
    input  wire [ITEM_BITS-1:0]                   right_data,
    output logic [ITEM_BITS-1:0]                  data,
    output logic                                  hit,
    output logic [ITEM_BITS-1:0]                  tap
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [IW-1:0] MY_IDX = IW'(IDX);
    localparam logic [CW-1:0] MY_CNT = CW'(IDX);

    logic [ITEM_BITS-1:0] entry_reg;
    logic [ITEM_BITS-1:0] entry_next;
    logic                 at_me;

    assign at_me = (at_idx == MY_IDX);

    always_comb
    begin
        entry_next = entry_reg;
        case (ctrl.op)
            idql_pkg::CELL_INS:
            begin
                if (MY_IDX > at_idx)
                    entry_next = left_data;
                else if (at_me)
                    entry_next = item;
            end
            idql_pkg::CELL_REM:
            begin
                if (MY_IDX >= at_idx)
                    entry_next = right_data;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    // entries at or past count are stale and never match
    always_comb
    begin
        if (ctrl.cmp_en)
            hit = (MY_CNT < count) && (entry_reg == item);
        else
            hit = ctrl.rd_en && at_me;
        tap = (ctrl.rd_en && at_me) ? entry_reg : '0;
    end

    assign data = entry_reg;

endmodule

`default_nettype wire

>>> hw/rtl/idql_scan.sv
// group-wise first-hit scan over the captured cell hit and tap lines
`default_nettype none

module idql_scan #(
    parameter int CAPACITY  = idql_pkg::CAPACITY_DEF,
    parameter int ITEM_BITS = idql_pkg::ITEM_BITS_DEF
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   load,
    input  wire [CAPACITY-1:0]                    hits,
    input  wire [CAPACITY-1:0][ITEM_BITS-1:0]     taps,
    output idql_pkg::scan_stat_t                  stat,
    output logic [$clog2(CAPACITY)-1:0]           index,
    output logic [ITEM_BITS-1:0]                  data
);

    localparam int G  = idql_pkg::GROUP_W;
    localparam int NG = (CAPACITY + G - 1) / G;
    localparam int SW = NG * G;
    localparam int GW = (NG > 1) ? $clog2(NG) : 1;
    localparam int IW = $clog2(CAPACITY);

    logic                          busy_reg;
    logic                          busy_next;
    logic [GW-1:0]                 grp_reg;
    logic [GW-1:0]                 grp_next;
    logic [SW-1:0]                 hit_reg;
    logic [SW-1:0]                 hit_next;
    logic [ITEM_BITS-1:0]          data_reg;
    logic [ITEM_BITS-1:0]          data_next;
    logic                          any_low;
    logic                          last_grp;
    logic [2:0]                    first_pos;
    logic [ITEM_BITS-1:0]          low_or;

    assign any_low  = |hit_reg[G-1:0];
    assign last_grp = (grp_reg == GW'(NG - 1));

    // lowest set bit of the current group, highest first so the lowest wins
    always_comb
    begin
        first_pos = '0;
        low_or    = '0;
        for (int k = G - 1; k >= 0; k--)
        begin
            if (hit_reg[k])
                first_pos = 3'(k);
        end
        // only the read cell drives a nonzero tap
        for (int k = 0; k < CAPACITY; k++)
        begin
            low_or = low_or | taps[k];
        end
    end

    always_comb
    begin
        stat.done  = busy_reg && (any_low || last_grp);
        stat.found = any_low;
        index      = IW'({grp_reg, first_pos});
        data       = data_reg;
    end

    always_comb
    begin
        busy_next = busy_reg;
        grp_next  = grp_reg;
        hit_next  = hit_reg;
        data_next = data_reg;
        if (load)
        begin
            busy_next = 1'b1;
            grp_next  = '0;
            hit_next  = SW'(hits);
            data_next = low_or;
        end
        else if (busy_reg)
        begin
            if (any_low || last_grp)
                busy_next = 1'b0;
            else
            begin
                grp_next = grp_reg + GW'(1);
                hit_next = hit_reg >> G;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            grp_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            grp_reg  <= grp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg  <= hit_next;
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

>>> hw/rtl/indexed_deque_list_engine.sv
// indexed deque list engine: row of storage cells under a command sequencer
// add, clear and failing ops pass from input accept through EXEC and DONE to the result
// pops, peeks, removes and finds also pass through SCAN, which steps over groups of 8 cells
// for the first hit, from 1 to ceil(CAPACITY/8) groups; tail reads and late finds scan longest
// one item in flight; a new item is taken only once the last result is in the output register
// rst_n asynchronous active low: list length zero, cell contents left unknown
`default_nettype none

module indexed_deque_list_engine #(
    parameter int CAPACITY  = idql_pkg::CAPACITY_DEF,
    parameter int ITEM_BITS = idql_pkg::ITEM_BITS_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [39:0] s_tdata,   // position[7:0], item_value[39:8]
    input  wire  [3:0]  s_tuser,   // mode[3:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [55:0] m_tdata    // ok[0], status[2:1], data_out[34:3],
                                   // found_index[40:35], length[47:41],
                                   // empty_res[48], zero[55:49]
);

    localparam int IW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > idql_pkg::POS_W) ? CW : idql_pkg::POS_W;

    idql_pkg::fsm_t                     state_reg;
    idql_pkg::fsm_t                     state_next;

    logic [idql_pkg::MODE_W-1:0]        mode_reg;
    logic [idql_pkg::POS_W-1:0]         pos_reg;
    logic [ITEM_BITS-1:0]               item_reg;
    logic [CW-1:0]                      count_reg;
    logic [CW-1:0]                      count_next;

    logic                               res_ok_reg;
    logic                               res_ok_next;
    logic [idql_pkg::STATUS_W-1:0]      res_status_reg;
    logic [idql_pkg::STATUS_W-1:0]      res_status_next;
    logic [idql_pkg::VALUE_W-1:0]       res_data_reg;
    logic [idql_pkg::VALUE_W-1:0]       res_data_next;
    logic [idql_pkg::FIDX_W-1:0]        res_fidx_reg;
    logic [idql_pkg::FIDX_W-1:0]        res_fidx_next;

    logic                               m_tvalid_reg;
    logic                               m_tvalid_next;
    logic [55:0]                        m_tdata_reg;
    logic [55:0]                        m_tdata_next;

    idql_pkg::cell_ctrl_t               ctrl;
    logic [IW-1:0]                      at_idx;
    logic                               need_scan;
    logic                               scan_load;
    logic                               in_acc;
    logic                               out_free;

    logic [CAPACITY-1:0][ITEM_BITS-1:0] cell_data;
    logic [CAPACITY-1:0][ITEM_BITS-1:0] cell_tap;
    logic [CAPACITY-1:0]                cell_hit;

    idql_pkg::scan_stat_t               scan_stat;
    logic [IW-1:0]                      scan_index;
    logic [ITEM_BITS-1:0]               scan_data;

    logic [CMPW-1:0]                    pos_ext;
    logic [CMPW-1:0]                    cnt_ext;
    logic                               full;
    logic                               empty;

    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign pos_ext  = CMPW'(pos_reg);
    assign cnt_ext  = CMPW'(count_reg);
    assign full     = (count_reg == CW'(CAPACITY));
    assign empty    = (count_reg == '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            idql_pkg::ST_IDLE:
            begin
                if (in_acc)
                    state_next = idql_pkg::ST_EXEC;
            end
            idql_pkg::ST_EXEC:
            begin
                state_next = need_scan ? idql_pkg::ST_SCAN : idql_pkg::ST_DONE;
            end
            idql_pkg::ST_SCAN:
            begin
                if (scan_stat.done)
                    state_next = idql_pkg::ST_DONE;
            end
            idql_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = idql_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = idql_pkg::ST_IDLE;
            end
        endcase
    end

    // command decode and result selection
    always_comb
    begin
        ctrl            = '{op: idql_pkg::CELL_HOLD, cmp_en: 1'b0, rd_en: 1'b0};
        at_idx          = '0;
        need_scan       = 1'b0;
        count_next      = count_reg;
        res_ok_next     = res_ok_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        res_fidx_next   = res_fidx_reg;
        s_tready        = (state_reg == idql_pkg::ST_IDLE);

        if (state_reg == idql_pkg::ST_EXEC)
        begin
            res_ok_next     = 1'b0;
            res_status_next = idql_pkg::STAT_OK;
            res_data_next   = '0;
            res_fidx_next   = '0;
            unique case (mode_reg) inside
                idql_pkg::MODE_APPEND, idql_pkg::MODE_APPEND_HEAD, idql_pkg::MODE_INSERT:
                begin
                    if (full)
                        res_status_next = idql_pkg::STAT_FULL;
                    else
                    begin
                        ctrl.op = idql_pkg::CELL_INS;
                        if (mode_reg == idql_pkg::MODE_APPEND_HEAD)
                            at_idx = '0;
                        else if (mode_reg == idql_pkg::MODE_INSERT && pos_ext < cnt_ext)
                            at_idx = IW'(pos_reg);
                        else
                            at_idx = IW'(count_reg);
                        count_next  = count_reg + CW'(1);
                        res_ok_next = 1'b1;
                    end
                end
                idql_pkg::MODE_POP_TAIL, idql_pkg::MODE_POP_HEAD,
                idql_pkg::MODE_PEEK_HEAD, idql_pkg::MODE_PEEK_TAIL:
                begin
                    if (empty)
                        res_status_next = idql_pkg::STAT_EMPTY;
                    else
                    begin
                        ctrl.rd_en = 1'b1;
                        need_scan  = 1'b1;
                        if (mode_reg == idql_pkg::MODE_POP_HEAD ||
                            mode_reg == idql_pkg::MODE_PEEK_HEAD)
                            at_idx = '0;
                        else
                            at_idx = IW'(count_reg - CW'(1));
                        if (mode_reg == idql_pkg::MODE_POP_HEAD ||
                            mode_reg == idql_pkg::MODE_POP_TAIL)
                        begin
                            ctrl.op    = idql_pkg::CELL_REM;
                            count_next = count_reg - CW'(1);
                        end
                    end
                end
                idql_pkg::MODE_REMOVE:
                begin
                    if (empty)
                        res_status_next = idql_pkg::STAT_EMPTY;
                    else if (pos_ext >= cnt_ext)
                        res_status_next = idql_pkg::STAT_RANGE;
                    else
                    begin
                        ctrl.op    = idql_pkg::CELL_REM;
                        ctrl.rd_en = 1'b1;
                        at_idx     = IW'(pos_reg);
                        need_scan  = 1'b1;
                        count_next = count_reg - CW'(1);
                    end
                end
                idql_pkg::MODE_FIND:
                begin
                    ctrl.cmp_en = 1'b1;
                    need_scan   = 1'b1;
                end
                idql_pkg::MODE_CLEAR:
                begin
                    count_next  = '0;
                    res_ok_next = 1'b1;
                end
                default:
                begin
                    res_status_next = idql_pkg::STAT_RANGE;
                end
            endcase
        end
        else if (state_reg == idql_pkg::ST_SCAN && scan_stat.done)
        begin
            // read ops always hit; only a find can come up empty
            res_ok_next     = scan_stat.found;
            res_status_next = scan_stat.found ? idql_pkg::STAT_OK : idql_pkg::STAT_EMPTY;
            res_data_next   = idql_pkg::VALUE_W'(scan_data);
            if (scan_stat.found && mode_reg == idql_pkg::MODE_FIND)
                res_fidx_next = idql_pkg::FIDX_W'(scan_index);
            else
                res_fidx_next = '0;
        end
    end

    assign scan_load = need_scan;

    // output register
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        if (state_reg == idql_pkg::ST_DONE && out_free)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {7'd0,
                             (count_reg == '0),
                             idql_pkg::LEN_W'(count_reg),
                             res_fidx_reg,
                             res_data_reg,
                             res_status_reg,
                             res_ok_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= idql_pkg::ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            mode_reg <= s_tuser;
            pos_reg  <= s_tdata[7:0];
            item_reg <= ITEM_BITS'(s_tdata[39:8]);
        end
        res_ok_reg     <= res_ok_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        res_fidx_reg   <= res_fidx_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [ITEM_BITS-1:0] left_in;
        logic [ITEM_BITS-1:0] right_in;

        if (i == 0)
        begin : g_first
            assign left_in = item_reg;
        end
        else
        begin : g_mid_l
            assign left_in = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_in = '0;
        end
        else
        begin : g_mid_r
            assign right_in = cell_data[i+1];
        end

        idql_cell #(
            .CAPACITY  (CAPACITY),
            .ITEM_BITS (ITEM_BITS),
            .IDX       (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .at_idx     (at_idx),
            .count      (count_reg),
            .item       (item_reg),
            .left_data  (left_in),
            .right_data (right_in),
            .data       (cell_data[i]),
            .hit        (cell_hit[i]),
            .tap        (cell_tap[i])
        );
    end

    idql_scan #(
        .CAPACITY  (CAPACITY),
        .ITEM_BITS (ITEM_BITS)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (scan_load),
        .hits  (cell_hit),
        .taps  (cell_tap),
        .stat  (scan_stat),
        .index (scan_index),
        .data  (scan_data)
    );

endmodule

`default_nettype wire

>>> hw/rtl/idql_checker.sv
// port-level checks for the indexed deque list engine, bound to the top level
`default_nettype none

module idql_checker #(
    parameter int CAPACITY = idql_pkg::CAPACITY_DEF
) (
    input wire        clk,
    input wire        rst_n,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [55:0] m_tdata
);

    localparam bit LEN_EXACT = (CAPACITY < 128);

    // a held result must not change
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // ok flag and status code agree
    a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] == (m_tdata[2:1] == 2'd0)))
        else $error("ok and status disagree");

    // a failed operation returns no data and no index
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> (m_tdata[34:3] == 32'd0) && (m_tdata[40:35] == 6'd0))
        else $error("failed item carries data");

    // empty flag follows length
    a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && LEN_EXACT |-> (m_tdata[48] == (m_tdata[47:41] == 7'd0)))
        else $error("empty flag and length disagree");

    // one item in flight: no accept right after an accept
    a_one_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

endmodule

bind indexed_deque_list_engine idql_checker #(
    .CAPACITY (CAPACITY)
) u_idql_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
